@@ rtl/plq_pkg.sv @@
package plq_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam int ID_W     = 64;
  localparam int QTY_W    = 32;
  localparam int SUM_W    = 40;
  localparam int PRICE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int ENTRY_W  = ID_W + QTY_W;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_REDUCE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_EXCEEDS   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [QTY_W-1:0] qty;
  } entry_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_FOUND  = 8'b0000_0100,
    S_MOVE   = 8'b0000_1000,
    S_HEAD   = 8'b0001_0000,
    S_HEADW  = 8'b0010_0000,
    S_FRONT  = 8'b0100_0000,
    S_FRONTW = 8'b1000_0000
  } state_t;

endpackage

@@ rtl/plq_ram.sv @@
module plq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/price_level_order_queue.sv @@
// One price level of an order book: a ring of (id, quantity) entries with a
// running quantity total.
// Input channel (in_valid/in_ready) carries one operation per beat: append,
// remove by id, pop front or reduce front quantity. Output channel
// (out_valid/out_ready) returns exactly one result beat per input beat, in
// order, with status, popped entry, new front entry, total, count and price.
// The level price is written through cfg_we/cfg_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// The block works on one operation at a time. A remove scans the live entries
// from the head, reading one entry per cycle through the single read port of
// the entry memory. The next input beat is taken in the cycle after a result
// is registered, so the block takes no new operation before the result of the
// last one is registered.
// Reset clears the count, head pointer, total and price; the entry memory is
// not cleared, since only live entries are ever read.
// A result held by a stalled receiver stays on the output until taken;
// the next input beat is accepted meanwhile and its result waits for it.
module price_level_order_queue #(
  parameter int DEPTH = plq_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic signed [plq_pkg::PRICE_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       operation,
  input  logic [plq_pkg::ID_W-1:0]         order_key,
  input  logic [plq_pkg::QTY_W-1:0]        quantity,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [plq_pkg::STATUS_W-1:0]     status,
  output logic [plq_pkg::ID_W-1:0]         popped_id,
  output logic [plq_pkg::QTY_W-1:0]        popped_qty,
  output logic [plq_pkg::ID_W-1:0]         front_id,
  output logic [plq_pkg::QTY_W-1:0]        front_qty,
  output logic [plq_pkg::SUM_W-1:0]        qty_total,
  output logic [$clog2(DEPTH+1)-1:0]       live_count,
  output logic                             is_empty,
  output logic signed [plq_pkg::PRICE_W-1:0] price_echo
);

  import plq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] wrap(input logic [CW:0] s);
    logic [CW:0] r;
    r = s;
    if (r >= (CW+1)'(DEPTH)) begin
      r = r - (CW+1)'(DEPTH);
    end
    return r[AW-1:0];
  endfunction

  state_t state;
  op_t    op_q;
  logic [ID_W-1:0]  id_q;
  logic [QTY_W-1:0] qty_q;
  status_t          status_q;
  logic [ID_W-1:0]  pop_id_q;
  logic [QTY_W-1:0] pop_qty_q;

  logic signed [PRICE_W-1:0] level_price;
  logic [AW-1:0]    head;
  logic [CW-1:0]    count;
  logic [SUM_W-1:0] sum;

  logic [CW-1:0] rd_idx;
  logic [CW-1:0] cmp_idx;
  logic [AW-1:0] cmp_slot;
  logic          cmp_valid;
  logic [AW-1:0] found_slot;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;

  logic          accept;
  logic [AW-1:0] scan_slot;
  logic [AW-1:0] last_slot;
  logic [AW-1:0] tail_slot;
  logic          is_full;
  logic          reduce_ok;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign rd_entry   = entry_t'(ram_rdata);
  assign scan_slot  = wrap((CW+1)'(head) + (CW+1)'(rd_idx));
  assign last_slot  = wrap((CW+1)'(head) + (CW+1)'(count - CW'(1)));
  assign tail_slot  = wrap((CW+1)'(head) + (CW+1)'(count));
  assign is_full    = (count == CW'(DEPTH));
  assign reduce_ok  = (qty_q <= rd_entry.qty);
  assign price_echo = level_price;

  plq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    unique case (state)
      S_SCAN:  ram_raddr = scan_slot;
      S_FOUND: ram_raddr = last_slot;
      default: ram_raddr = head;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head;
    ram_wdata = ram_rdata;
    unique case (state)
      S_IDLE: begin
        if (accept && op_t'(operation) == OP_APPEND && !is_full) begin
          ram_we    = 1'b1;
          ram_waddr = tail_slot;
          ram_wdata = {order_key, quantity};
        end
      end
      S_HEADW: begin
        if (op_q == OP_REDUCE && reduce_ok) begin
          ram_we    = 1'b1;
          ram_waddr = head;
          ram_wdata = {rd_entry.id, rd_entry.qty - qty_q};
        end
      end
      S_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = found_slot;
        ram_wdata = ram_rdata;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      level_price <= '0;
      head        <= '0;
      count       <= '0;
      sum         <= '0;
      out_valid   <= 1'b0;
      cmp_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        level_price <= cfg_data;
      end
      if (out_valid && out_ready && state != S_FRONTW) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q      <= op_t'(operation);
            id_q      <= order_key;
            qty_q     <= quantity;
            pop_id_q  <= '0;
            pop_qty_q <= '0;
            rd_idx    <= '0;
            cmp_valid <= 1'b0;
            unique case (op_t'(operation))
              OP_APPEND: begin
                if (is_full) begin
                  status_q <= ST_FULL;
                end else begin
                  status_q <= ST_OK;
                  count    <= count + CW'(1);
                  sum      <= sum + SUM_W'(quantity);
                end
                state <= S_FRONT;
              end
              OP_REMOVE: begin
                if (count == '0) begin
                  status_q <= ST_NOT_FOUND;
                  state    <= S_FRONT;
                end else begin
                  status_q <= ST_OK;
                  state    <= S_SCAN;
                end
              end
              default: begin
                if (count == '0) begin
                  status_q <= ST_EMPTY;
                  state    <= S_FRONT;
                end else begin
                  status_q <= ST_OK;
                  state    <= S_HEAD;
                end
              end
            endcase
          end
        end

        // Reads are issued one entry ahead of the compare of the data
        // returned for the previous read.
        S_SCAN: begin
          if (rd_idx < count) begin
            cmp_valid <= 1'b1;
            cmp_idx   <= rd_idx;
            cmp_slot  <= scan_slot;
            rd_idx    <= rd_idx + CW'(1);
          end else begin
            cmp_valid <= 1'b0;
          end
          if (cmp_valid) begin
            if (rd_entry.id == id_q) begin
              found_slot <= cmp_slot;
              sum        <= sum - SUM_W'(rd_entry.qty);
              state      <= S_FOUND;
            end else if (cmp_idx == count - CW'(1)) begin
              status_q <= ST_NOT_FOUND;
              state    <= S_FRONT;
            end
          end
        end

        S_FOUND: begin
          if (found_slot == last_slot) begin
            count <= count - CW'(1);
            state <= S_FRONT;
          end else begin
            state <= S_MOVE;
          end
        end

        S_MOVE: begin
          count <= count - CW'(1);
          state <= S_FRONT;
        end

        S_HEAD: begin
          state <= S_HEADW;
        end

        S_HEADW: begin
          if (op_q == OP_POP) begin
            pop_id_q  <= rd_entry.id;
            pop_qty_q <= rd_entry.qty;
            sum       <= sum - SUM_W'(rd_entry.qty);
            head      <= wrap((CW+1)'(head) + (CW+1)'(1));
            count     <= count - CW'(1);
          end else if (reduce_ok) begin
            sum <= sum - SUM_W'(qty_q);
          end else begin
            status_q <= ST_EXCEEDS;
          end
          state <= S_FRONT;
        end

        S_FRONT: begin
          state <= S_FRONTW;
        end

        // The head read address stays put, so the read data holds while the
        // previous result is still waiting to be taken.
        S_FRONTW: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            status     <= status_q;
            popped_id  <= pop_id_q;
            popped_qty <= pop_qty_q;
            front_id   <= (count == '0) ? '0 : rd_entry.id;
            front_qty  <= (count == '0) ? '0 : rd_entry.qty;
            qty_total  <= sum;
            live_count <= count;
            is_empty   <= (count == '0);
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import plq_pkg::*;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct {
    status_t                   status;
    logic [ID_W-1:0]           popped_id;
    logic [QTY_W-1:0]          popped_qty;
    logic [ID_W-1:0]           front_id;
    logic [QTY_W-1:0]          front_qty;
    logic [SUM_W-1:0]          qty_total;
    logic [CNT_W-1:0]          live_count;
    logic                      is_empty;
    logic signed [PRICE_W-1:0] price;
  } level_snapshot_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic signed [PRICE_W-1:0] cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                operation;
  logic [ID_W-1:0]           order_key;
  logic [QTY_W-1:0]          quantity;
  logic                      out_valid;
  logic                      out_ready;
  logic [STATUS_W-1:0]       status;
  logic [ID_W-1:0]           popped_id;
  logic [QTY_W-1:0]          popped_qty;
  logic [ID_W-1:0]           front_id;
  logic [QTY_W-1:0]          front_qty;
  logic [SUM_W-1:0]          qty_total;
  logic [CNT_W-1:0]          live_count;
  logic                      is_empty;
  logic signed [PRICE_W-1:0] price_echo;

  price_level_order_queue #(.DEPTH(DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .order_key(order_key),
    .quantity(quantity),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .popped_id(popped_id),
    .popped_qty(popped_qty),
    .front_id(front_id),
    .front_qty(front_qty),
    .qty_total(qty_total),
    .live_count(live_count),
    .is_empty(is_empty),
    .price_echo(price_echo)
  );

  // Shadow copy of the price level, advanced once per accepted input beat.
  logic [ID_W-1:0]           level_ids  [DEPTH];
  logic [QTY_W-1:0]          level_qtys [DEPTH];
  int unsigned               level_head;
  int unsigned               level_count;
  logic [SUM_W-1:0]          level_total;
  logic signed [PRICE_W-1:0] level_price;

  level_snapshot_t pending_snapshots[$];
  logic [ID_W-1:0] id_pool [8];
  int unsigned     mismatch_count = 0;
  int unsigned     cycle_count = 0;
  logic            steady_flow = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned slot_at(int unsigned offset);
    return (level_head + offset) % DEPTH;
  endfunction

  function automatic level_snapshot_t predict_level_step(op_t op, logic [ID_W-1:0] id,
                                                         logic [QTY_W-1:0] qty);
    level_snapshot_t r;
    int unsigned s, last, i;
    logic hit;
    r.status     = ST_OK;
    r.popped_id  = '0;
    r.popped_qty = '0;
    case (op)
      OP_APPEND: begin
        if (level_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          s = slot_at(level_count);
          level_ids[s]  = id;
          level_qtys[s] = qty;
          level_count++;
          level_total = level_total + qty;
        end
      end
      OP_REMOVE: begin
        r.status = ST_NOT_FOUND;
        hit = 1'b0;
        for (i = 0; i < level_count && !hit; i++) begin
          s = slot_at(i);
          if (level_ids[s] == id) begin
            hit = 1'b1;
            level_total = level_total - level_qtys[s];
            // The last live entry fills the hole, so order breaks here.
            last = slot_at(level_count - 1);
            if (s != last) begin
              level_ids[s]  = level_ids[last];
              level_qtys[s] = level_qtys[last];
            end
          end
        end
        if (hit) begin
          level_count--;
          r.status = ST_OK;
        end
      end
      OP_POP: begin
        if (level_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_id  = level_ids[level_head];
          r.popped_qty = level_qtys[level_head];
          level_total  = level_total - r.popped_qty;
          level_head   = slot_at(1);
          level_count--;
        end
      end
      default: begin
        if (level_count == 0) begin
          r.status = ST_EMPTY;
        end else if (qty > level_qtys[level_head]) begin
          r.status = ST_EXCEEDS;
        end else begin
          level_qtys[level_head] = level_qtys[level_head] - qty;
          level_total = level_total - qty;
        end
      end
    endcase
    r.front_id   = (level_count != 0) ? level_ids[level_head] : '0;
    r.front_qty  = (level_count != 0) ? level_qtys[level_head] : '0;
    r.qty_total  = level_total;
    r.live_count = level_count[CNT_W-1:0];
    r.is_empty   = (level_count == 0);
    r.price      = level_price;
    return r;
  endfunction

  function automatic string describe(level_snapshot_t s);
    return $sformatf("status=%0d popped=%h/%h front=%h/%h total=%h count=%0d empty=%b price=%0d",
                     s.status, s.popped_id, s.popped_qty, s.front_id, s.front_qty,
                     s.qty_total, s.live_count, s.is_empty, s.price);
  endfunction

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ID_W-1:0] random_id();
    return {$urandom, $urandom};
  endfunction

  // Ids are drawn from a small pool often enough that duplicates occur.
  function automatic logic [ID_W-1:0] append_id();
    if ($urandom_range(0, 99) < 60) return id_pool[$urandom_range(0, 7)];
    return random_id();
  endfunction

  function automatic logic [ID_W-1:0] remove_id();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (level_count != 0 && r < 70)
      return level_ids[slot_at($urandom_range(0, level_count - 1))];
    if (r < 85) return id_pool[$urandom_range(0, 7)];
    return random_id();
  endfunction

  function automatic logic [QTY_W-1:0] random_qty();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [QTY_W-1:0] reduce_amount();
    logic [QTY_W-1:0] front;
    if (level_count == 0) return random_qty();
    front = level_qtys[level_head];
    case ($urandom_range(0, 9))
      0:       return front;
      1:       return (front == '1) ? $urandom : front + 32'd1 + $urandom_range(0, 100);
      2:       return random_qty();
      default: return $urandom_range(0, front);
    endcase
  endfunction

  task automatic send_order(op_t op, logic [ID_W-1:0] id, logic [QTY_W-1:0] qty);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation = op;
    order_key = id;
    quantity  = qty;
    in_valid  = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_snapshots.insert(pending_snapshots.size(), predict_level_step(op, id, qty));
  endtask

  task automatic wait_level_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_snapshots.size() != 0) @(negedge clk);
  endtask

  task automatic write_level_price(logic signed [PRICE_W-1:0] price);
    wait_level_idle();
    cfg_we   = 1'b1;
    cfg_data = price;
    @(negedge clk);
    cfg_we      = 1'b0;
    level_price = price;
  endtask

  task automatic test_empty_level();
    send_order(OP_POP, random_id(), random_qty());
    send_order(OP_REDUCE, random_id(), 32'd5);
    send_order(OP_REMOVE, random_id(), random_qty());
  endtask

  task automatic test_append_extremes();
    send_order(OP_APPEND, '0, '0);
    send_order(OP_APPEND, '1, '1);
    send_order(OP_APPEND, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
    send_order(OP_APPEND, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
  endtask

  // Front entry starts with quantity zero, so a reduce by one must be refused.
  task automatic test_front_ops();
    send_order(OP_REDUCE, random_id(), 32'd1);
    send_order(OP_REDUCE, random_id(), 32'd0);
    send_order(OP_POP, random_id(), random_qty());
    send_order(OP_REDUCE, random_id(), '1);
    send_order(OP_REDUCE, random_id(), 32'd1);
  endtask

  task automatic test_remove_cases();
    send_order(OP_REMOVE, 64'h1234, random_qty());
    send_order(OP_REMOVE, 64'h5555_5555_5555_5555, random_qty());
    send_order(OP_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA, random_qty());
    send_order(OP_REMOVE, '1, random_qty());
    // With a repeated id only the entry nearest the head goes.
    send_order(OP_APPEND, 64'd7, 32'd10);
    send_order(OP_APPEND, 64'd7, 32'd20);
    send_order(OP_REMOVE, 64'd7, random_qty());
    send_order(OP_POP, random_id(), random_qty());
  endtask

  task automatic test_full_level();
    while (level_count < DEPTH) send_order(OP_APPEND, append_id(), random_qty());
    repeat (3) send_order(OP_APPEND, random_id(), random_qty());
    while (level_count > 0) send_order(OP_REMOVE, remove_id(), $urandom);
  endtask

  task automatic test_random_mix(int unsigned n_items);
    int unsigned append_weight, r;
    append_weight = 50;
    for (int unsigned k = 0; k < n_items; k++) begin
      // Swing the fill level between nearly empty and full.
      if (k % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       append_weight = 20;
          1:       append_weight = 45;
          default: append_weight = 75;
        endcase
        steady_flow = ($urandom_range(0, 4) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < append_weight) begin
        send_order(OP_APPEND, append_id(), random_qty());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45)
          send_order(OP_REMOVE, remove_id(), $urandom);
        else if (r < 75)
          send_order(OP_POP, random_id(), $urandom);
        else
          send_order(OP_REDUCE, random_id(), reduce_amount());
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    operation   = OP_APPEND;
    order_key   = '0;
    quantity    = '0;
    level_head  = 0;
    level_count = 0;
    level_total = '0;
    level_price = '0;
    id_pool[0]  = '0;
    id_pool[1]  = '1;
    for (int i = 2; i < 8; i++) id_pool[i] = random_id();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_level_price(32'sh8000_0000);
    test_empty_level();
    test_append_extremes();
    test_front_ops();
    test_remove_cases();
    write_level_price(32'sh7FFF_FFFF);
    test_full_level();
    write_level_price('0);
    test_random_mix(390);
    write_level_price($urandom);
    test_random_mix(390);
    write_level_price(-32'sd1);
    test_random_mix(390);
    write_level_price($urandom);
    test_random_mix(390);

    wait_level_idle();
    repeat (DEPTH + 8) @(posedge clk);
    mismatch_count += pending_snapshots.size();
    if (mismatch_count == 0) begin
      $display("[price_level_order_queue] OK");
    end else begin
      $display("[price_level_order_queue] ERROR");
    end
    $finish;
  end

  // Receiver: runs of ready broken by stalls of random length.
  initial begin
    int unsigned run_len, stall_len;
    out_ready = 1'b0;
    forever begin
      run_len   = $urandom_range(1, 12);
      out_ready = 1'b1;
      repeat (run_len) @(negedge clk);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_ready = 1'b0;
        repeat (stall_len) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    level_snapshot_t got, want;
    if (!rst && out_valid && out_ready) begin
      got.status     = status_t'(status);
      got.popped_id  = popped_id;
      got.popped_qty = popped_qty;
      got.front_id   = front_id;
      got.front_qty  = front_qty;
      got.qty_total  = qty_total;
      got.live_count = live_count;
      got.is_empty   = is_empty;
      got.price      = price_echo;
      if (pending_snapshots.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat: %s", describe(got));
      end else begin
        want = pending_snapshots[0];
        pending_snapshots.delete(0);
        if (got.status !== want.status || got.popped_id !== want.popped_id ||
            got.popped_qty !== want.popped_qty || got.front_id !== want.front_id ||
            got.front_qty !== want.front_qty || got.qty_total !== want.qty_total ||
            got.live_count !== want.live_count || got.is_empty !== want.is_empty ||
            got.price !== want.price) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(got));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[price_level_order_queue] ERROR");
      $finish;
    end
  end

endmodule
